// ===== sv/gtg_pkg.sv =====
package gtg_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int AtanEntries = 24;

    localparam logic signed [19:0] AngPi     = 20'sd205887;
    localparam logic signed [19:0] AngHalfPi = 20'sd102944;
    localparam logic signed [20:0] AngTwoPi  = 21'sd411775;
    localparam logic [15:0] InvGainQ16 = 16'd39797;

    localparam logic [2:0] CFG_SPEED_GAIN  = 3'd0;
    localparam logic [2:0] CFG_TURN_GAIN   = 3'd1;
    localparam logic [2:0] CFG_ARRIVAL     = 3'd2;
    localparam logic [2:0] CFG_CLAMP       = 3'd3;
    localparam logic [2:0] CFG_SAFETY      = 3'd4;

    localparam logic [15:0] RstSpeedGain = 16'd8192;
    localparam logic [15:0] RstTurnGain  = 16'd15565;
    localparam logic [31:0] RstArrival   = 32'd19661;
    localparam logic [31:0] RstClamp     = 32'd65536;
    localparam logic [15:0] RstSafety    = 16'd49152;

    typedef struct packed {
        logic               func;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               estimator_ready;
        logic [15:0]        safety_prob;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] linear_cmd;
        logic signed [15:0] angular_cmd;
        logic               goal_reached;
        logic               safety_blocked;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_word_t;

    function automatic logic [16:0] atan_lookup(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:  r = 17'd51472;
            5'd1:  r = 17'd30385;
            5'd2:  r = 17'd16054;
            5'd3:  r = 17'd8150;
            5'd4:  r = 17'd4091;
            5'd5:  r = 17'd2047;
            5'd6:  r = 17'd1024;
            5'd7:  r = 17'd512;
            5'd8:  r = 17'd256;
            5'd9:  r = 17'd128;
            5'd10: r = 17'd64;
            5'd11: r = 17'd32;
            5'd12: r = 17'd16;
            5'd13: r = 17'd8;
            5'd14: r = 17'd4;
            5'd15: r = 17'd2;
            5'd16: r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/gtg_if.sv =====
interface gtg_in_if;
    import gtg_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gtg_out_if;
    import gtg_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gtg_cfg_if;
    import gtg_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/go_to_goal_pose_controller_top.sv =====
// Channel   Dir  Word
// in_ch     in   func, goal, pose, quaternion, estimator_ready, safety_prob
// out_ch    out  linear_cmd, angular_cmd, goal_reached, safety_blocked
// cfg_ch    in   register index and data, always ready
//
// A goal word only loads the goal and arms the controller. A control tick runs
// the quaternion products, two passes through the shared CORDIC unit (a zero
// vector skips the iterations), the heading error, the two gain products and
// the last step, which puts its result in the output register; no new word is
// taken until that tick is done. Other ticks give no result.
// A new word is taken while a result waits in the output register; a finished
// tick holds in its last step until that register is free.
// Reset is asynchronous and active low; it disarms the controller and loads the
// default gains, radius, clamp and safety threshold.
module go_to_goal_pose_controller_top #(
    parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    gtg_in_if.sink     in_ch,
    gtg_out_if.source  out_ch,
    gtg_cfg_if.sink    cfg_ch
);
    import gtg_pkg::*;

    // Configuration registers, to be written while the block is idle; the block itself does not enforce this.
    logic [15:0] speed_gain, turn_gain, safety_threshold;
    logic [31:0] arrival_radius, distance_clamp;

    gtg_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_ch),
        .speed_gain       (speed_gain),
        .turn_gain        (turn_gain),
        .arrival_radius   (arrival_radius),
        .distance_clamp   (distance_clamp),
        .safety_threshold (safety_threshold)
    );

    // The sequencer owns the goal state and drives the shared CORDIC unit.
    gtg_seq #(.CORDIC_STEPS(CORDIC_STEPS)) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_data          (in_ch.data),
        .in_valid         (in_ch.valid),
        .in_ready         (in_ch.ready),
        .out_data         (out_ch.data),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .speed_gain       (speed_gain),
        .turn_gain        (turn_gain),
        .arrival_radius   (arrival_radius),
        .distance_clamp   (distance_clamp),
        .safety_threshold (safety_threshold)
    );

endmodule

// ===== sv/gtg_cordic.sv =====
module gtg_cordic #(
    parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [35:0]  x_in,
    input  logic signed [35:0]  y_in,
    output logic                done,
    output logic signed [20:0]  angle,
    output logic [36:0]         mag
);
    import gtg_pkg::*;

    localparam int CntW = $clog2(CORDIC_STEPS + 1);

    // 38-bit datapath: |x|,|y| < 2^34 grow by at most K < 1.65.
    logic signed [37:0] x_reg, x_next, y_reg, y_next;
    logic signed [20:0] z_reg, z_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [37:0] xs, ys, xe, ye;
    logic [4:0]         idx;

    assign idx = 5'(cnt_reg);
    assign xs  = x_reg >>> idx;
    assign ys  = y_reg >>> idx;
    assign xe  = 38'(x_in);
    assign ye  = 38'(y_in);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = '0;
            if (x_in == 36'sd0 && y_in == 36'sd0)
            begin
                x_next    = '0;
                y_next    = '0;
                z_next    = '0;
                done_next = 1'b1;
            end
            else if (x_in < 0)
            begin
                x_next    = -xe;
                y_next    = -ye;
                z_next    = (y_in >= 0) ? 21'(AngPi) : -21'(AngPi);
                busy_next = 1'b1;
            end
            else
            begin
                x_next    = xe;
                y_next    = ye;
                z_next    = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CntW'(CORDIC_STEPS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (y_reg >= 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + 21'(atan_lookup(idx));
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - 21'(atan_lookup(idx));
                end
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;
    assign mag   = x_reg[36:0];

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= CntW'(CORDIC_STEPS)) else $error("step count overrun");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("start while busy");

endmodule

// ===== sv/gtg_seq.sv =====
module gtg_seq #(
    parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtg_pkg::in_word_t    in_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    output gtg_pkg::out_word_t   out_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic [15:0]          speed_gain,
    input  logic [15:0]          turn_gain,
    input  logic [31:0]          arrival_radius,
    input  logic [31:0]          distance_clamp,
    input  logic [15:0]          safety_threshold
);
    import gtg_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_Q0    = 4'd1;
    localparam logic [3:0] S_Q1    = 4'd2;
    localparam logic [3:0] S_Q2    = 4'd3;
    localparam logic [3:0] S_Q3    = 4'd4;
    localparam logic [3:0] S_C1    = 4'd5;
    localparam logic [3:0] S_W1    = 4'd6;
    localparam logic [3:0] S_C2    = 4'd7;
    localparam logic [3:0] S_W2    = 4'd8;
    localparam logic [3:0] S_ERR   = 4'd9;
    localparam logic [3:0] S_REM   = 4'd10;
    localparam logic [3:0] S_MULL  = 4'd11;
    localparam logic [3:0] S_MULA  = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0]         state_reg, state_next;
    logic               armed_reg;
    logic signed [31:0] tx_reg, ty_reg;
    in_word_t           in_reg;
    logic signed [35:0] qa_reg, qb_reg;     // yaw vector x and y
    logic signed [35:0] acc_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [20:0] bearing_reg;
    logic [31:0]        dist_reg;
    logic               dist_hi_reg;        // distance exceeds 32 bits
    logic signed [22:0] err_reg;
    logic signed [51:0] prod_reg;
    logic signed [15:0] lin_reg;
    logic               ovalid_reg;
    out_word_t          odata_reg;

    // Single shared 17x17 signed multiplier for the quaternion products.
    logic signed [16:0] m_a, m_b;
    logic signed [33:0] m_p;
    assign m_p = m_a * m_b;

    logic               c_start, c_done;
    logic signed [35:0] c_x, c_y;
    logic signed [20:0] c_angle;
    logic [36:0]        c_mag;
    logic [53:0]        dist_full;
    logic signed [22:0] err_raw;
    logic signed [22:0] err_rem;
    logic               behind;
    logic [32:0]        vmag;
    logic signed [33:0] vlin;
    logic signed [34:0] gain_op;
    logic signed [16:0] g_a;
    logic signed [51:0] g_p;
    logic signed [51:0] rounded;
    logic               reached, blocked;
    logic               fin_go;

    gtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .x_in  (c_x),
        .y_in  (c_y),
        .done  (c_done),
        .angle (c_angle),
        .mag   (c_mag)
    );

    assign c_start = (state_reg == S_C1) || (state_reg == S_C2);
    assign c_x = (state_reg == S_C1) ? 36'(dx_reg) : qa_reg;
    assign c_y = (state_reg == S_C1) ? 36'(dy_reg) : qb_reg;

    always_comb
    begin
        m_a = 17'(in_reg.quat_w);
        m_b = 17'(in_reg.quat_w);
        case (state_reg)
            S_Q0:
            begin
                m_a = 17'(in_reg.quat_w);
                m_b = 17'(in_reg.quat_w);
            end
            S_Q1:
            begin
                m_a = 17'(in_reg.quat_x);
                m_b = 17'(in_reg.quat_x);
            end
            S_Q2:
            begin
                m_a = 17'(in_reg.quat_y);
                m_b = -17'(in_reg.quat_y);
            end
            S_Q3:
            begin
                m_a = 17'(in_reg.quat_z);
                m_b = -17'(in_reg.quat_z);
            end
            S_C1:
            begin
                m_a = 17'(in_reg.quat_x);
                m_b = 17'(in_reg.quat_y);
            end
            S_W1:
            begin
                m_a = 17'(in_reg.quat_w);
                m_b = 17'(in_reg.quat_z);
            end
            default:
            begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Distance: raw magnitude times 1/K, rounded; computed once on the first
    // CORDIC pass completion (37 x 16 bits, registered right after).
    assign dist_full = 54'(c_mag) * 54'(InvGainQ16) + 54'd32768;

    assign err_raw = 23'(bearing_reg) - 23'(c_angle) + 23'(AngHalfPi) + 23'(AngPi);
    // |err_raw| < 3*2pi, so truncated remainder takes at most two corrections;
    // one is done in S_ERR and one in S_REM, which also subtracts pi.
    assign err_rem = (err_reg >= 23'(AngTwoPi)) ? err_reg - 23'(AngTwoPi) :
                     (err_reg <= -23'(AngTwoPi)) ? err_reg + 23'(AngTwoPi) : err_reg;

    assign behind = (err_reg > 23'(AngHalfPi)) || (err_reg < -23'(AngHalfPi));
    assign vmag   = (dist_hi_reg || dist_reg >= distance_clamp) ?
                    {1'b0, distance_clamp} : {1'b0, dist_reg};
    assign vlin   = behind ? -34'(vmag) : 34'(vmag);
    assign gain_op = (state_reg == S_MULL) ? 35'(vlin) : 35'(err_reg);

    // Shared gain multiplier: speed gain times speed term, then turn gain
    // times heading error. The full product needs up to 49 bits.
    assign g_a = $signed({1'b0, (state_reg == S_MULL) ? speed_gain : turn_gain});
    assign g_p = g_a * gain_op;

    assign rounded = prod_reg + ((state_reg == S_FIN) ? 52'sd524288 : 52'sd131072);

    function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
        logic signed [15:0] r;
        if (v > 52'sd32767)
            r = 16'sd32767;
        else if (v < -52'sd32768)
            r = -16'sd32768;
        else
            r = v[15:0];
        return r;
    endfunction

    assign reached = dist_hi_reg ? 1'b0 : (dist_reg < arrival_radius);
    assign blocked = in_reg.safety_prob < safety_threshold;

    // The last step waits while the previous result still sits in the
    // output register.
    assign fin_go = (state_reg == S_FIN) && (!ovalid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                    state_next = (in_data.func && armed_reg && in_data.estimator_ready) ?
                                 S_Q0 : S_IDLE;
            S_Q0:   state_next = S_Q1;
            S_Q1:   state_next = S_Q2;
            S_Q2:   state_next = S_Q3;
            S_Q3:   state_next = S_C1;
            S_C1:   state_next = S_W1;
            S_W1:   state_next = c_done ? S_C2 : S_W1;
            S_C2:   state_next = S_W2;
            S_W2:   state_next = c_done ? S_ERR : S_W2;
            S_ERR:  state_next = S_REM;
            S_REM:  state_next = S_MULL;
            S_MULL: state_next = S_MULA;
            S_MULA: state_next = S_FIN;
            S_FIN:  state_next = fin_go ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            armed_reg  <= 1'b0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= fin_go || (ovalid_reg && !out_ready);
            if (in_valid && in_ready && !in_data.func)
            begin
                tx_reg    <= in_data.goal_x;
                ty_reg    <= in_data.goal_y;
                armed_reg <= 1'b1;
            end
            if (fin_go && reached)
                armed_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
            dx_reg <= 33'(tx_reg) - 33'(in_data.pose_x);
            dy_reg <= 33'(ty_reg) - 33'(in_data.pose_y);
        end
        case (state_reg)
            S_Q0: acc_reg <= 36'(m_p);
            S_Q1, S_Q2, S_Q3: acc_reg <= acc_reg + 36'(m_p);
            S_C1:
            begin
                qa_reg  <= acc_reg;
                acc_reg <= 36'(m_p);
            end
            S_W1:
            begin
                if (c_done)
                begin
                    bearing_reg <= c_angle;
                    dist_reg    <= dist_full[47:16];
                    dist_hi_reg <= |dist_full[53:48];
                    qb_reg      <= 36'((acc_reg + 36'(m_p)) <<< 1);
                end
            end
            S_W2:
                if (c_done)
                    err_reg <= err_raw;
            S_ERR:  err_reg <= err_rem;
            S_REM:  err_reg <= err_rem - 23'(AngPi);
            S_MULL: prod_reg <= g_p;
            S_MULA:
            begin
                lin_reg  <= sat16(rounded >>> 18);
                prod_reg <= g_p;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    odata_reg.goal_reached   <= reached;
                    odata_reg.safety_blocked <= blocked;
                    odata_reg.linear_cmd     <= (reached || blocked) ? 16'sd0 : lin_reg;
                    odata_reg.angular_cmd    <= (reached || blocked) ? 16'sd0 :
                                                sat16(rounded >>> 20);
                end
            end
            default: ;
        endcase
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> out_valid) else $error("result lost");
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MULL) |-> (err_reg >= -23'(AngPi) - 23'(AngTwoPi)) &&
        (err_reg < 23'(AngTwoPi))) else $error("heading error out of range");

endmodule

// ===== sv/gtg_cfg.sv =====
module gtg_cfg (
    input  logic        clk,
    input  logic        rst_n,
    gtg_cfg_if.sink     cfg,
    output logic [15:0] speed_gain,
    output logic [15:0] turn_gain,
    output logic [31:0] arrival_radius,
    output logic [31:0] distance_clamp,
    output logic [15:0] safety_threshold
);
    import gtg_pkg::*;

    logic [15:0] sg_reg, tg_reg, st_reg;
    logic [31:0] ar_reg, dc_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_reg <= RstSpeedGain;
            tg_reg <= RstTurnGain;
            ar_reg <= RstArrival;
            dc_reg <= RstClamp;
            st_reg <= RstSafety;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_SPEED_GAIN: sg_reg <= cfg.data.data[15:0];
                CFG_TURN_GAIN:  tg_reg <= cfg.data.data[15:0];
                CFG_ARRIVAL:    ar_reg <= cfg.data.data;
                CFG_CLAMP:      dc_reg <= cfg.data.data;
                CFG_SAFETY:     st_reg <= cfg.data.data[15:0];
                default: ;
            endcase
        end
    end

    assign speed_gain       = sg_reg;
    assign turn_gain        = tg_reg;
    assign arrival_radius   = ar_reg;
    assign distance_clamp   = dc_reg;
    assign safety_threshold = st_reg;

endmodule

// ===== tb/go_to_goal_pose_controller_top_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the go-to-goal pose controller.
// Goal and tick words are sent on in_ch, commands are collected on out_ch, and
// register writes go through cfg_ch while the block is idle. A bit-accurate
// predictor inside a small scoreboard class computes the expected command for
// every accepted tick that gives one and checks the commands in order.
module go_to_goal_pose_controller_top_tb;
    import gtg_pkg::*;

    localparam int Steps = CordicStepsDefault;
    localparam int SettleCycles = 2 * Steps + 40;

    // Scoreboard: holds the predictor state and the queue of pending commands.
    class gtg_scoreboard;
        longint    speed_gain, turn_gain, arrival_radius, distance_clamp, safety_threshold;
        longint    goal_x_r, goal_y_r;
        bit        armed;
        out_word_t pending_cmds[$];
        int        mismatches;

        function void reset_state();
            speed_gain = RstSpeedGain;
            turn_gain = RstTurnGain;
            arrival_radius = RstArrival;
            distance_clamp = RstClamp;
            safety_threshold = RstSafety;
            goal_x_r = 0;
            goal_y_r = 0;
            armed = 0;
            mismatches = 0;
            pending_cmds.delete();
        endfunction

        function void note_register(cfg_word_t w);
            case (w.index)
                CFG_SPEED_GAIN: speed_gain = w.data[15:0];
                CFG_TURN_GAIN:  turn_gain = w.data[15:0];
                CFG_ARRIVAL:    arrival_radius = w.data;
                CFG_CLAMP:      distance_clamp = w.data;
                CFG_SAFETY:     safety_threshold = w.data[15:0];
                default: ;
            endcase
        endfunction

        // Floor division by a power of two.
        function longint floor_shift(longint v, int s);
            if (v >= 0)
                return v >>> s;
            return -(((-v) - 1) >>> s) - 1;
        endfunction

        function longint clip16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        // Vectoring CORDIC: returns the angle, raw magnitude through mag.
        function longint vector_angle(longint x, longint y, output longint mag);
            longint z;
            longint xs;
            longint ys;
            z = 0;
            if (x == 0 && y == 0)
            begin
                mag = 0;
                return 0;
            end
            if (x < 0)
            begin
                z = (y >= 0) ? longint'(AngPi) : -longint'(AngPi);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < Steps && i < AtanEntries; i++)
            begin
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z += longint'(atan_lookup(i[4:0]));
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z -= longint'(atan_lookup(i[4:0]));
                end
            end
            mag = x;
            return z;
        endfunction

        function void note_input(in_word_t w);
            longint dx, dy, qx, qy, qz, qw, mag, bearing, yaw, herr, v, lin, ang;
            longint dist_q;
            bit reached, blocked;
            out_word_t r;
            if (w.func == 1'b0)
            begin
                goal_x_r = longint'(w.goal_x);
                goal_y_r = longint'(w.goal_y);
                armed = 1;
                return;
            end
            if (!armed || !w.estimator_ready)
                return;
            dx = goal_x_r - longint'(w.pose_x);
            dy = goal_y_r - longint'(w.pose_y);
            qx = w.quat_x;
            qy = w.quat_y;
            qz = w.quat_z;
            qw = w.quat_w;
            bearing = vector_angle(dx, dy, mag);
            dist_q = (mag * longint'(InvGainQ16) + 32768) >>> 16;
            yaw = vector_angle(qw * qw + qx * qx - qy * qy - qz * qz,
                               2 * (qx * qy + qw * qz), mag);
            herr = bearing - (yaw - longint'(AngHalfPi)) + longint'(AngPi);
            herr = (herr % longint'(AngTwoPi)) - longint'(AngPi);
            v = (dist_q < distance_clamp) ? dist_q : distance_clamp;
            if (herr > longint'(AngHalfPi) || herr < -longint'(AngHalfPi))
                v = -v;
            lin = clip16(floor_shift(speed_gain * v + (longint'(1) << 17), 18));
            ang = clip16(floor_shift(turn_gain * herr + (longint'(1) << 19), 20));
            reached = dist_q < arrival_radius;
            if (reached)
            begin
                armed = 0;
                lin = 0;
                ang = 0;
            end
            blocked = longint'(w.safety_prob) < safety_threshold;
            if (blocked)
            begin
                lin = 0;
                ang = 0;
            end
            r.linear_cmd = lin[15:0];
            r.angular_cmd = ang[15:0];
            r.goal_reached = reached;
            r.safety_blocked = blocked;
            pending_cmds.push_back(r);
        endfunction

        function void check_command(out_word_t got);
            out_word_t exp_cmd;
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected command word: %p", got);
                mismatches++;
                return;
            end
            exp_cmd = pending_cmds.pop_front();
            if (got.linear_cmd !== exp_cmd.linear_cmd)
            begin
                $error("linear_cmd: expected %0d, actual %0d",
                       exp_cmd.linear_cmd, got.linear_cmd);
                mismatches++;
            end
            if (got.angular_cmd !== exp_cmd.angular_cmd)
            begin
                $error("angular_cmd: expected %0d, actual %0d",
                       exp_cmd.angular_cmd, got.angular_cmd);
                mismatches++;
            end
            if (got.goal_reached !== exp_cmd.goal_reached)
            begin
                $error("goal_reached: expected %0b, actual %0b",
                       exp_cmd.goal_reached, got.goal_reached);
                mismatches++;
            end
            if (got.safety_blocked !== exp_cmd.safety_blocked)
            begin
                $error("safety_blocked: expected %0b, actual %0b",
                       exp_cmd.safety_blocked, got.safety_blocked);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gtg_in_if  in_ch ();
    gtg_out_if out_ch ();
    gtg_cfg_if cfg_ch ();

    go_to_goal_pose_controller_top #(
        .CORDIC_STEPS(Steps)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_ch(cfg_ch.sink)
    );

    gtg_scoreboard cmd_board;

    // Idle control. When calm is set, neither side inserts random gaps.
    bit calm;
    // Set while the receiver deliberately holds off to back up the block.
    bit hold_off;
    bit stim_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Safety net: ends the run if the handshakes never complete.
    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    // Sends one word on the input channel, at times with a random gap before it unless calm is set.
    task automatic send_word(input in_word_t w);
        if (!calm && $urandom_range(99) < 8)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        cmd_board.note_input(w);
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
    endtask

    // Leaves valid high so that writes can follow back to back; the caller
    // drops it after the last write.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        cfg_word_t w;
        w.index = idx;
        w.data = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cmd_board.note_register(w);
    endtask

    // Lets every pending command drain, then waits out any tick still inside
    // the block that will produce no command.
    task automatic wait_idle();
        release_input();
        while (cmd_board.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic in_word_t goal_word(input logic signed [31:0] gx,
                                           input logic signed [31:0] gy);
        in_word_t w;
        w = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.func = 1'b0;
        w.goal_x = gx;
        w.goal_y = gy;
        return w;
    endfunction

    function automatic logic signed [15:0] rand_quat();
        int r;
        r = $urandom_range(32768);
        return 16'(r - 16384);
    endfunction

    // A tick whose pose is near the goal most of the time, so ticks do not all
    // saturate, with occasional extreme positions.
    function automatic in_word_t tick_word(input logic signed [31:0] gx,
                                           input logic signed [31:0] gy);
        in_word_t w;
        int sel;
        w = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.func = 1'b1;
        sel = $urandom_range(9);
        if (sel < 7)
        begin
            w.pose_x = gx + 32'($signed($urandom_range(0, 400000)) - 200000);
            w.pose_y = gy + 32'($signed($urandom_range(0, 400000)) - 200000);
        end
        w.quat_x = rand_quat();
        w.quat_y = rand_quat();
        w.quat_z = rand_quat();
        w.quat_w = rand_quat();
        if ($urandom_range(19) == 0)
            {w.quat_x, w.quat_y, w.quat_z, w.quat_w} = '0;
        w.estimator_ready = ($urandom_range(9) != 0);
        w.safety_prob = ($urandom_range(4) == 0) ? 16'($urandom) :
                        16'($urandom_range(49152, 65535));
        return w;
    endfunction

    // Receiver: stalls at random and checks each accepted command.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                cmd_board.check_command(out_ch.data);
            if (hold_off)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    // Long hold-off on the output, counted here, while the sender keeps going.
    initial
    begin
        hold_off = 1'b0;
        wait (stim_done == 1'b0 && cmd_board != null && rst_n === 1'b1);
        wait (hold_off == 1'b1);
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        in_word_t w;
        logic signed [31:0] gx, gy;
        logic [31:0] corner_vals[4];
        int sent;

        cmd_board = new();
        cmd_board.reset_state();
        calm = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings.
        // A tick before any goal gives no command.
        send_word(tick_word(0, 0));
        // Robot exactly at goal, with a zero quaternion.
        w = tick_word(0, 0);
        send_word(goal_word(32'sd0, 32'sd0));
        w.pose_x = 0;
        w.pose_y = 0;
        w.estimator_ready = 1'b1;
        w.safety_prob = 16'hFFFF;
        {w.quat_x, w.quat_y, w.quat_z, w.quat_w} = '0;
        send_word(w);
        // Extreme goal and pose fields, both signs.
        corner_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        foreach (corner_vals[i])
        begin
            send_word(goal_word(corner_vals[i], corner_vals[3 - i]));
            w = tick_word(0, 0);
            w.pose_x = corner_vals[3 - i];
            w.pose_y = corner_vals[i];
            w.quat_x = (i % 2) ? 16'sh4000 : -16'sh4000;
            w.quat_w = (i % 2) ? -16'sh4000 : 16'sh4000;
            w.quat_y = (i < 2) ? 16'sh4000 : -16'sh4000;
            w.quat_z = (i < 2) ? -16'sh4000 : 16'sh4000;
            w.estimator_ready = 1'b1;
            w.safety_prob = (i == 2) ? 16'h0000 : 16'hFFFF;
            send_word(w);
            // Estimator not ready: ignored.
            w.estimator_ready = 1'b0;
            send_word(w);
        end
        // Safety block together with goal reached.
        send_word(goal_word(32'sd100, -32'sd100));
        w = tick_word(100, -100);
        w.pose_x = 100;
        w.pose_y = -100;
        w.estimator_ready = 1'b1;
        w.safety_prob = 16'd0;
        send_word(w);
        wait_idle();

        // Random phases, each with its own register settings but phase 2, which keeps those of phase 1.
        sent = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(CFG_SPEED_GAIN, 32'hFFFF);
                    write_register(CFG_TURN_GAIN, 32'hFFFF);
                    write_register(CFG_ARRIVAL, 32'h0);
                    write_register(CFG_CLAMP, 32'hFFFF_FFFF);
                    write_register(CFG_SAFETY, 32'h0);
                end
                1:
                begin
                    write_register(CFG_SPEED_GAIN, 32'h0);
                    write_register(CFG_TURN_GAIN, 32'h0);
                    write_register(CFG_ARRIVAL, 32'hFFFF_FFFF);
                    write_register(CFG_CLAMP, 32'h0);
                    write_register(CFG_SAFETY, 32'hFFFF);
                end
                // An index outside the register map is ignored.
                2: write_register(3'd7, $urandom);
                default:
                begin
                    write_register(CFG_SPEED_GAIN, $urandom);
                    write_register(CFG_TURN_GAIN, $urandom);
                    write_register(CFG_ARRIVAL, $urandom_range(0, 150000));
                    write_register(CFG_CLAMP, $urandom_range(0, 300000));
                    write_register(CFG_SAFETY, $urandom_range(0, 60000));
                end
            endcase
            cfg_ch.valid <= 1'b0;
            calm = (phase == 3);
            for (int n = 0; n < 100; n++)
            begin
                if (phase == 4 && n == 10)
                    hold_off = 1'b1;
                if ($urandom_range(7) == 0 || n == 0)
                begin
                    gx = $urandom;
                    gy = $urandom;
                    if ($urandom_range(1))
                    begin
                        gx = 32'($signed($urandom_range(0, 2000000)) - 1000000);
                        gy = 32'($signed($urandom_range(0, 2000000)) - 1000000);
                    end
                    send_word(goal_word(gx, gy));
                end
                send_word(tick_word(gx, gy));
                sent++;
            end
            calm = 1'b0;
            wait_idle();
        end

        stim_done = 1'b1;
        wait_idle();
        if (cmd_board.mismatches == 0 && cmd_board.pending_cmds.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
